@@ rtl/rzn_pkg.sv @@
// Shared constants for the rolling z-score normalizer.
// No dependencies.
package rzn_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int WINDOW_DEF  = 256;

    localparam int ZW        = 15;
    localparam int ZMAX_Q12  = 20480;
    localparam int QB        = 32;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    localparam logic [8:0] WINDOW_RST = 9'd256;
    localparam logic [4:0] ACTIVE_RST = 5'd16;

endpackage

@@ rtl/rolling_zscore_normalizer.sv @@
// A push runs the load, evict, update, multiply, difference and prepare states, then the 32-step
// divider and the 15-step square root; a saturating quotient skips the divider and zero variance
// skips both. An inactive column goes straight to the result state; a clear returns nothing.
// One item at a time: the input is ready only while idle, and a clear leaves the block idle.
// Reset: all columns empty (per-column valid bits clear), window 256, 16 active columns.
// Uses rzn_pkg.
module rolling_zscore_normalizer
    import rzn_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int WINDOW  = WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [3:0]         column_index,
    input  logic signed [23:0] sample_value,
    input  logic               is_missing,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         result_column,
    output logic signed [15:0] zscore,
    output logic               status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NW    = $clog2(WINDOW + 1);
    localparam int PW    = $clog2(WINDOW);
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int SUM_W = 24 + PW;
    localparam int SQ_W  = 47 + PW;
    localparam int NQ_W  = NW + SQ_W;
    localparam int SS_W  = 2 * SUM_W;
    localparam int NX_W  = NW + 25;
    localparam int A_W   = NX_W + 1;
    localparam int B_W   = NW + NQ_W;
    localparam int R_W   = 2 * A_W + 26;
    localparam int DW    = ((R_W > B_W + QB) ? R_W : B_W + QB) + 1;

    typedef struct packed {
        logic [NW-1:0]           fill;
        logic [PW-1:0]           wpos;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
    } colst_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_EVICT, S_UPD, S_MUL, S_DIFF, S_PREP, S_OVF, S_DIV, S_SQRT, S_RES
    } state_t;

    state_t                  state_reg;
    logic [8:0]              window_length_reg;
    logic [4:0]              active_columns_reg;
    logic [COLUMNS-1:0]      col_valid_reg;
    logic [CW-1:0]           col_reg;
    logic [3:0]              colraw_reg;
    logic signed [23:0]      x_reg;
    logic [47:0]             xsq_reg;
    logic [47:0]             oldsq_reg;
    logic signed [23:0]      old_reg;
    logic                    evict_reg;
    colst_t                  cur_reg;
    colst_t                  colmem_rd_reg;
    logic signed [23:0]      samp_rd_reg;
    logic [NW-1:0]           n_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic [SQ_W-1:0]         q_reg;
    logic [NQ_W-1:0]         nq_reg;
    logic [SS_W-1:0]         ss_reg;
    logic signed [NX_W-1:0]  nx_reg;
    logic [NQ_W-1:0]         dvar_reg;
    logic [A_W-1:0]          a_reg;
    logic                    neg_reg;
    logic [B_W-1:0]          b_reg;
    logic [DW-1:0]           rem_reg;
    logic [DW-1:0]           dsh_reg;
    logic [QB-1:0]           quo_reg;
    logic [4:0]              cnt_reg;
    logic [ZW-1:0]           r_reg;
    logic [ZW-1:0]           bit_reg;
    logic signed [15:0]      zres_reg;
    logic                    stat_reg;
    logic                    out_valid_reg;
    logic [3:0]              out_col_reg;
    logic signed [15:0]      out_z_reg;
    logic                    out_stat_reg;

    colst_t                  colmem [COLUMNS];
    logic signed [23:0]      sampmem [COLUMNS][WINDOW];

    logic                    cfg_wr;
    logic                    res_load;
    logic [NW-1:0]           win_eff;
    logic                    col_bad;
    logic [CW-1:0]           col_in;
    colst_t                  cs;
    logic                    evict;
    logic [PW+1:0]           rpos_tmp;
    logic [PW-1:0]           rpos;
    logic signed [23:0]      old_v;
    colst_t                  upd;
    logic [SUM_W-1:0]        sabs;
    logic signed [A_W-1:0]   num;
    logic [ZW-1:0]           cand;
    logic [ZW:0]             tval;
    logic [2*ZW+1:0]         tsq;
    logic [ZW-1:0]           zmag;
    logic [A_W-1:0]          a_sq_dummy;

    assign cfg_wr        = psel & penable & pwrite;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_WINDOW) ? {23'd0, window_length_reg}
                                                    : {27'd0, active_columns_reg};
    assign in_ready      = (state_reg == S_IDLE);
    assign res_load      = (state_reg == S_RES) && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign result_column = out_col_reg;
    assign zscore        = out_z_reg;
    assign status        = out_stat_reg;
    assign a_sq_dummy    = a_reg;

    always_comb
    begin
        if (window_length_reg == 9'd0)
            win_eff = NW'(1);
        else if (32'(window_length_reg) > WINDOW)
            win_eff = NW'(WINDOW);
        else
            win_eff = NW'(window_length_reg);
        col_bad = (32'(column_index) >= ((32'(active_columns_reg) > COLUMNS)
                                         ? COLUMNS : 32'(active_columns_reg)));
        col_in  = CW'({4'd0, column_index});
    end

    always_comb
    begin
        cs       = col_valid_reg[col_reg] ? colmem_rd_reg : '0;
        evict    = ({1'b0, cs.fill} >= {1'b0, win_eff});
        rpos_tmp = (PW+2)'(cs.wpos) + (PW+2)'(WINDOW) - (PW+2)'(cs.fill);
        if (32'(rpos_tmp) >= WINDOW)
            rpos_tmp = rpos_tmp - (PW+2)'(WINDOW);
        rpos  = rpos_tmp[PW-1:0];
        old_v = evict_reg ? samp_rd_reg : 24'sd0;
    end

    always_comb
    begin
        upd.fill  = cur_reg.fill - NW'(evict_reg) + NW'(1);
        upd.wpos  = (32'(cur_reg.wpos) == WINDOW - 1) ? '0 : cur_reg.wpos + PW'(1);
        upd.sum   = cur_reg.sum - SUM_W'(old_reg) + SUM_W'(x_reg);
        upd.sumsq = cur_reg.sumsq - SQ_W'(oldsq_reg) + SQ_W'(xsq_reg);
        sabs      = s_reg[SUM_W-1] ? SUM_W'(~s_reg + 1'b1) : SUM_W'(s_reg);
        num       = A_W'(nx_reg) - A_W'(s_reg);
        cand      = r_reg | bit_reg;
        tval      = {cand, 1'b0} - (ZW+1)'(1);
        tsq       = (2*ZW+2)'(tval) * (2*ZW+2)'(tval);
        zmag      = (32'(r_reg) > ZMAX_Q12) ? ZW'(ZMAX_Q12) : r_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            colmem_rd_reg <= colmem[col_in];
        if (state_reg == S_UPD)
            colmem[col_reg] <= upd;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
            samp_rd_reg <= sampmem[col_reg][rpos];
        if (state_reg == S_UPD)
            sampmem[col_reg][cur_reg.wpos] <= x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            window_length_reg  <= WINDOW_RST;
            active_columns_reg <= ACTIVE_RST;
            col_valid_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_WINDOW)
                    window_length_reg <= pwdata[8:0];
                else
                    active_columns_reg <= pwdata[4:0];
            end
            if ((cfg_wr && paddr[2] == REG_WINDOW)
                || (state_reg == S_IDLE && in_valid && operation == OP_CLEAR))
                col_valid_reg <= '0;
            else if (state_reg == S_UPD)
                col_valid_reg[col_reg] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        col_reg    <= col_in;
                        colraw_reg <= column_index;
                        x_reg      <= is_missing ? 24'sd0 : sample_value;
                        if (operation != OP_CLEAR)
                        begin
                            if (col_bad)
                            begin
                                zres_reg  <= 16'sd0;
                                stat_reg  <= 1'b1;
                                state_reg <= S_RES;
                            end
                            else
                                state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    cur_reg   <= cs;
                    evict_reg <= evict;
                    xsq_reg   <= 48'(x_reg * x_reg);
                    state_reg <= S_EVICT;
                end
                S_EVICT:
                begin
                    old_reg   <= old_v;
                    oldsq_reg <= 48'(old_v * old_v);
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    n_reg     <= upd.fill;
                    s_reg     <= upd.sum;
                    q_reg     <= upd.sumsq;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    nq_reg    <= NQ_W'(n_reg) * NQ_W'(q_reg);
                    ss_reg    <= SS_W'(sabs) * SS_W'(sabs);
                    nx_reg    <= NX_W'($signed({1'b0, n_reg}) * x_reg);
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    dvar_reg  <= nq_reg - NQ_W'(ss_reg);
                    neg_reg   <= num[A_W-1];
                    a_reg     <= num[A_W-1] ? A_W'(-num) : A_W'(num);
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    b_reg   <= B_W'(n_reg) * B_W'(dvar_reg);
                    rem_reg <= DW'(R_W'(a_sq_dummy) * R_W'(a_reg)) << 26;
                    stat_reg <= 1'b0;
                    if (dvar_reg == '0)
                    begin
                        zres_reg  <= 16'sd0;
                        state_reg <= S_RES;
                    end
                    else
                        state_reg <= S_OVF;
                end
                S_OVF:
                begin
                    dsh_reg <= DW'(b_reg) << (QB - 1);
                    cnt_reg <= 5'(QB - 1);
                    r_reg   <= '0;
                    bit_reg <= ZW'(1) << (ZW - 1);
                    if (rem_reg >= (DW'(b_reg) << QB))
                    begin
                        quo_reg   <= '1;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        quo_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                        quo_reg <= {quo_reg[QB-2:0], 1'b1};
                    end
                    else
                        quo_reg <= {quo_reg[QB-2:0], 1'b0};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (32'(tsq) <= quo_reg)
                        r_reg <= cand;
                    bit_reg <= bit_reg >> 1;
                    if (bit_reg[0])
                        state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (res_load)
                    begin
                        out_col_reg   <= colraw_reg;
                        out_stat_reg  <= stat_reg;
                        if (stat_reg || dvar_reg == '0)
                            out_z_reg <= 16'sd0;
                        else
                            out_z_reg <= neg_reg ? -$signed(16'(zmag)) : $signed(16'(zmag));
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (zscore == 16'sd0))
        else $error("error result carries nonzero zscore");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (zscore <= 16'sd20480 && zscore >= -16'sd20480))
        else $error("zscore outside clip range");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == OP_CLEAR) |=> (col_valid_reg == '0))
        else $error("clear left a column valid");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> $onehot(bit_reg))
        else $error("square root bit mask lost");
`endif

endmodule

@@ tb/rolling_zscore_normalizer_checker.sv @@
// Checker for the rolling z-score normalizer: watches the input, output and APB
// channels, predicts each z-score with exact integer math and compares in order.
// Depends on rzn_pkg.
module rolling_zscore_normalizer_checker
    import rzn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               operation,
    input  logic [3:0]         column_index,
    input  logic signed [23:0] sample_value,
    input  logic               is_missing,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [3:0]         result_column,
    input  logic signed [15:0] zscore,
    input  logic               status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_INACTIVE = 1'b1;
    localparam int   EXP_DEPTH       = 64;

    typedef struct packed {
        logic [3:0]         col;
        logic signed [15:0] z;
        logic               st;
    } zscore_t;

    zscore_t            expected_scores[EXP_DEPTH];
    int                 exp_wr;
    int                 exp_rd;
    logic signed [23:0] ring[COLUMNS_DEF][WINDOW_DEF];
    int                 fill[COLUMNS_DEF];
    int                 wpos[COLUMNS_DEF];
    longint             col_sum[COLUMNS_DEF];
    logic [63:0]        col_sumsq[COLUMNS_DEF];
    logic [8:0]         window_len;
    logic [4:0]         active_cols;

    function automatic void clear_history();
        for (int i = 0; i < COLUMNS_DEF; i++)
        begin
            fill[i] = 0;
            wpos[i] = 0;
            col_sum[i] = 0;
            col_sumsq[i] = 0;
        end
    endfunction

    function automatic zscore_t normalize(logic [3:0] col, logic signed [23:0] val, logic miss);
        zscore_t     r;
        int          act;
        int          w;
        int          n;
        int          lo;
        int          hi;
        int          mid;
        longint      x;
        longint      old;
        longint      s;
        longint      num;
        logic [127:0] sabs;
        logic [127:0] dvar;
        logic [127:0] a13;
        logic [127:0] b;
        logic [127:0] rhs;
        logic [127:0] t;
        r.col = col;
        r.z = '0;
        r.st = STATUS_OK;
        act = (active_cols > COLUMNS_DEF) ? COLUMNS_DEF : int'(active_cols);
        if (col >= act)
        begin
            r.st = STATUS_INACTIVE;
            return r;
        end
        x = miss ? 0 : longint'(val);
        w = (window_len == 0) ? 1 : ((window_len > WINDOW_DEF) ? WINDOW_DEF : int'(window_len));
        if (fill[col] >= w)
        begin
            old = ring[col][(wpos[col] + WINDOW_DEF - fill[col]) % WINDOW_DEF];
            col_sum[col] -= old;
            col_sumsq[col] -= 64'(old * old);
            fill[col]--;
        end
        ring[col][wpos[col]] = 24'(x);
        wpos[col] = (wpos[col] + 1) % WINDOW_DEF;
        col_sum[col] += x;
        col_sumsq[col] += 64'(x * x);
        fill[col]++;
        n = fill[col];
        s = col_sum[col];
        sabs = 128'((s < 0) ? -s : s);
        dvar = 128'(n) * 128'(col_sumsq[col]) - sabs * sabs;
        if (dvar == 0)
            return r;
        num = longint'(n) * x - s;
        a13 = 128'((num < 0) ? -num : num) << 13;
        b = dvar * 128'(n);
        rhs = a13 * a13;
        lo = 0;
        hi = ZMAX_Q12;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 128'(2 * mid - 1);
            if (b * t * t <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        r.z = (num < 0) ? -16'(lo) : 16'(lo);
        return r;
    endfunction

    assign pending = exp_wr - exp_rd;

    always @(posedge clk or negedge rst_n)
    begin
        zscore_t e;
        if (!rst_n)
        begin
            clear_history();
            window_len = WINDOW_RST;
            active_cols = ACTIVE_RST;
            exp_wr = 0;
            exp_rd = 0;
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WINDOW)
                begin
                    window_len = pwdata[8:0];
                    clear_history();
                end
                else
                    active_cols = pwdata[4:0];
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_CLEAR)
                    clear_history();
                else
                begin
                    expected_scores[exp_wr % EXP_DEPTH] =
                        normalize(column_index, sample_value, is_missing);
                    exp_wr++;
                end
            end
            if (out_valid && out_ready)
            begin
                if (exp_wr == exp_rd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: col %0d z %0d status %0d",
                                 result_column, zscore, status);
                end
                else
                begin
                    e = expected_scores[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (e.col !== result_column || e.z !== zscore || e.st !== status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected col %0d z %0d status %0d, got col %0d z %0d status %0d",
                                     e.col, e.z, e.st, result_column, zscore, status);
                    end
                end
            end
        end
    end

endmodule

@@ tb/rolling_zscore_normalizer_tb.sv @@
// Top of the rolling z-score normalizer testbench: clock, reset, APB setup,
// directed and random sample transfers with input idling and output stalls; verdict from the checker.
// Depends on rzn_pkg, rolling_zscore_normalizer and rolling_zscore_normalizer_checker.
module rolling_zscore_normalizer_tb;
    import rzn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               operation;
    logic [3:0]         column_index;
    logic signed [23:0] sample_value;
    logic               is_missing;
    logic               out_valid;
    logic               out_ready;
    logic [3:0]         result_column;
    logic signed [15:0] zscore;
    logic               status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;
    int                 idle_pct;
    int                 stall_pct;
    int                 hold_req;
    int                 hold_cnt;
    logic signed [23:0] base_val[16];

    rolling_zscore_normalizer dut (.*);

    rolling_zscore_normalizer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("rolling_zscore_normalizer test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_cnt == 0 && hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send(logic op, logic [3:0] col, logic signed [23:0] val, logic miss);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        column_index <= col;
        sample_value <= val;
        is_missing <= miss;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic regsel, logic [31:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int count, int cols);
        logic [3:0]         col;
        logic signed [23:0] val;
        int                 kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            col = 4'($urandom_range(cols - 1));
            if ($urandom_range(9) == 0)
                col = 4'($urandom_range(15));
            if (kind < 45)
                val = base_val[col] + 24'($signed($urandom_range(4000)) - 2000);
            else if (kind < 60)
                val = base_val[col];
            else if (kind < 70)
                val = 24'($urandom);
            else if (kind < 78)
                val = ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
            else
                val = base_val[col] + 24'($signed($urandom_range(400000)) - 200000);
            if (kind >= 98)
                send(OP_CLEAR, 4'($urandom), 24'($urandom), 1'($urandom));
            else
                send(OP_PUSH, col, val, ($urandom_range(19) == 0));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_PUSH;
        column_index = '0;
        sample_value = '0;
        is_missing = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_cnt = 0;
        for (int i = 0; i < 16; i++)
            base_val[i] = 24'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_PUSH, 4'd0, 24'sh7FFFFF, 1'b0);
        send(OP_PUSH, 4'd0, 24'sh7FFFFF, 1'b0);
        send(OP_PUSH, 4'd0, 24'sh800000, 1'b0);
        send(OP_PUSH, 4'd0, 24'sh000000, 1'b0);
        send(OP_PUSH, 4'd0, 24'sh123456, 1'b1);
        send(OP_PUSH, 4'd15, 24'sh800000, 1'b0);
        send(OP_PUSH, 4'd15, 24'sh7FFFFF, 1'b0);
        send(OP_PUSH, 4'd3, 24'sh000100, 1'b0);
        send(OP_PUSH, 4'd3, 24'sh000100, 1'b0);
        send(OP_PUSH, 4'd3, 24'sh000100, 1'b0);
        send(OP_CLEAR, 4'd7, 24'sh5A5A5A, 1'b1);
        send(OP_PUSH, 4'd0, 24'sh7FFFFF, 1'b0);
        for (int i = 0; i < 8; i++)
            send(OP_PUSH, 4'd5, 24'sh000000, 1'b0);
        send(OP_PUSH, 4'd5, 24'sh7FFFFF, 1'b0);
        send(OP_PUSH, 4'd5, 24'sh800000, 1'b0);

        write_reg(REG_WINDOW, 32'd4);
        write_reg(REG_ACTIVE, 32'd16);
        random_items(250, 16);

        write_reg(REG_WINDOW, 32'd1);
        write_reg(REG_ACTIVE, 32'd5);
        idle_pct = 68;
        random_items(200, 6);

        write_reg(REG_WINDOW, 32'd511);
        write_reg(REG_ACTIVE, 32'd31);
        idle_pct = 0;
        stall_pct = 68;
        hold_req = 600;
        random_items(300, 16);

        write_reg(REG_WINDOW, 32'd2);
        write_reg(REG_ACTIVE, 32'd1);
        idle_pct = 29;
        stall_pct = 29;
        random_items(150, 2);

        write_reg(REG_WINDOW, 32'd0);
        write_reg(REG_ACTIVE, 32'd0);
        idle_pct = 0;
        stall_pct = 0;
        random_items(50, 4);

        write_reg(REG_WINDOW, 32'd256);
        write_reg(REG_ACTIVE, 32'd2);
        idle_pct = 29;
        stall_pct = 29;
        random_items(300, 2);

        write_reg(REG_WINDOW, 32'd20);
        write_reg(REG_ACTIVE, 32'd12);
        idle_pct = 0;
        stall_pct = 0;
        random_items(280, 13);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("rolling_zscore_normalizer test passed");
        else
            $display("rolling_zscore_normalizer test failed");
        $finish;
    end

endmodule
